@@ hdl/sle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared codes, widths and types of the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int STS_W    = 2;
    localparam int FOUND_W  = 7;
    localparam int LEN_W    = 8;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_READ      = 3'd1;
    localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE    = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL      = 2'd1;
    localparam logic [STS_W-1:0] STS_BAD_INDEX = 2'd2;
    localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                    apply;
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } ctrl_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] value;
        logic [FOUND_W-1:0]      index;
    } probe_t;

endpackage

@@ hdl/sle_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_in_if
// Request channel: one list operation per item.
// ----------------------------------------------------------------------------
interface sle_in_if;
    import sle_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;

    modport source (output valid, output operation, output position, output item_value,
                    input ready);
    modport sink   (input valid, input operation, input position, input item_value,
                    output ready);
endinterface

@@ hdl/sle_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_out_if
// Response channel: one result item per request.
// ----------------------------------------------------------------------------
interface sle_out_if;
    import sle_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STS_W-1:0]        status;
    logic signed [VAL_W-1:0] read_value;
    logic [FOUND_W-1:0]      found_index;
    logic [LEN_W-1:0]        list_length;

    modport source (output valid, output status, output read_value, output found_index,
                    output list_length, input ready);
    modport sink   (input valid, input status, input read_value, input found_index,
                    input list_length, output ready);
endinterface

@@ hdl/sequential_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed 32-bit entries kept in a chain of cells, with
// insert, read, overwrite, search, delete and clear.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  req      in   operation, position, item_value                  valid/ready
//  rsp      out  status, read_value, found_index, list_length     valid/ready
//
//  read, search and delete pass through a scan step, in which the probe walks
//  the cell chain one cell per cycle.
//  insert, overwrite, clear and unused codes skip the scan and go to the apply step.
//  one item is worked on at a time; a new item is taken while a result waits.
//  reset clears the length, step, scan timer and result valid; entries stay undefined until written.
//  a stalled rsp holds the next result in its last step until the slot frees.
// ----------------------------------------------------------------------------
module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int LIST_DEPTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    sle_in_if.sink     req,
    sle_out_if.source  rsp
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int TMR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t                  state_reg;
    state_t                  state_next;
    logic [OP_W-1:0]         op_reg;
    logic [POS_W-1:0]        pos_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [TMR_W-1:0]        timer_reg;
    logic [TMR_W-1:0]        timer_next;

    logic [STS_W-1:0]        res_status_reg;
    logic signed [VAL_W-1:0] res_value_reg;
    logic [FOUND_W-1:0]      res_found_reg;
    logic [LEN_W-1:0]        res_length_reg;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [STS_W-1:0]        out_status_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic [FOUND_W-1:0]      out_found_reg;
    logic [LEN_W-1:0]        out_length_reg;

    logic                    accept;
    logic                    is_scan_op;
    logic                    scan_last;
    logic                    out_free;
    logic                    load_result;
    logic                    exec_ok;
    logic                    exec_apply;
    logic [STS_W-1:0]        exec_status;
    logic signed [VAL_W-1:0] exec_value;
    logic [FOUND_W-1:0]      exec_found;
    logic [CNT_W-1:0]        exec_count;
    logic [CMP_W-1:0]        pos_x;
    logic [CMP_W-1:0]        cnt_x;

    ctrl_t                   cell_ctrl;
    logic                    cell_apply;
    logic signed [VAL_W-1:0] cell_value [LIST_DEPTH];
    probe_t                  cell_probe [LIST_DEPTH];
    probe_t                  probe_tail;

    assign accept      = req.valid && req.ready;
    assign is_scan_op  = (req.operation == OP_READ) || (req.operation == OP_SEARCH)
                         || (req.operation == OP_DELETE);
    assign scan_last   = timer_reg == TMR_W'(LIST_DEPTH - 1);
    assign out_free    = !out_valid_reg || rsp.ready;
    assign probe_tail  = cell_probe[LIST_DEPTH-1];
    assign pos_x       = CMP_W'(pos_reg);
    assign cnt_x       = CMP_W'(count_reg);

    // operation outcome, valid once the probe has reached the chain end
    always_comb
    begin
        exec_ok     = 1'b1;
        exec_apply  = 1'b0;
        exec_status = STS_OK;
        exec_value  = '0;
        exec_found  = '0;
        exec_count  = count_reg;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (count_reg >= CNT_W'(LIST_DEPTH))
                begin
                    exec_ok     = 1'b0;
                    exec_status = STS_FULL;
                end
                else if (pos_x > cnt_x)
                begin
                    exec_ok     = 1'b0;
                    exec_status = STS_BAD_INDEX;
                end
                else
                begin
                    exec_apply = 1'b1;
                    exec_count = count_reg + CNT_W'(1);
                end
            end
            OP_READ:
            begin
                exec_ok = probe_tail.hit;
                if (probe_tail.hit)
                    exec_value = probe_tail.value;
            end
            OP_OVERWRITE:
            begin
                exec_ok    = pos_x < cnt_x;
                exec_apply = pos_x < cnt_x;
            end
            OP_SEARCH:
            begin
                exec_ok = probe_tail.hit;
                if (probe_tail.hit)
                    exec_found = probe_tail.index;
            end
            OP_DELETE:
            begin
                exec_ok    = probe_tail.hit;
                exec_apply = probe_tail.hit;
                if (probe_tail.hit)
                begin
                    exec_value = probe_tail.value;
                    exec_count = count_reg - CNT_W'(1);
                end
            end
            OP_CLEAR:
            begin
                exec_count = '0;
            end
            default:
            begin
                exec_ok = 1'b1;
            end
        endcase
        if (exec_ok)
            exec_status = STS_OK;
        else if (op_reg == OP_SEARCH)
            exec_status = STS_NOT_FOUND;
        else if (op_reg != OP_INSERT)
            exec_status = STS_BAD_INDEX;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = is_scan_op ? S_SCAN : S_APPLY;
            end
            S_SCAN:
            begin
                if (scan_last)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req.ready   = 1'b0;
        load_result = 1'b0;
        count_next  = count_reg;
        timer_next  = timer_reg;
        cell_apply  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready  = 1'b1;
                timer_next = '0;
            end
            S_SCAN:
            begin
                timer_next = timer_reg + TMR_W'(1);
            end
            S_APPLY:
            begin
                cell_apply = exec_apply;
                count_next = exec_count;
            end
            S_DONE:
            begin
                load_result = out_free;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign cell_ctrl.apply      = cell_apply;
    assign cell_ctrl.op         = op_reg;
    assign cell_ctrl.position   = pos_reg;
    assign cell_ctrl.item_value = val_reg;

    assign out_valid_next = load_result ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            timer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            timer_reg     <= timer_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.operation;
            pos_reg <= req.position;
            val_reg <= req.item_value;
        end
        if (state_reg == S_APPLY)
        begin
            res_status_reg <= exec_status;
            res_value_reg  <= exec_value;
            res_found_reg  <= exec_found;
            res_length_reg <= LEN_W'(exec_count);
        end
        if (load_result)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_found_reg  <= res_found_reg;
            out_length_reg <= res_length_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++)
        begin : g_cell
            logic signed [VAL_W-1:0] left_w;
            logic signed [VAL_W-1:0] right_w;
            probe_t                  probe_w;

            if (g == 0)
            begin : g_first
                assign left_w  = val_reg;
                assign probe_w = '0;
            end
            else
            begin : g_inner
                assign left_w  = cell_value[g-1];
                assign probe_w = cell_probe[g-1];
            end

            if (g == LIST_DEPTH - 1)
            begin : g_last
                assign right_w = cell_value[g];
            end
            else
            begin : g_mid
                assign right_w = cell_value[g+1];
            end

            sle_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .count       (count_reg),
                .left_value  (left_w),
                .right_value (right_w),
                .probe_in    (probe_w),
                .value       (cell_value[g]),
                .probe_out   (cell_probe[g])
            );
        end
    endgenerate

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.found_index = out_found_reg;
    assign rsp.list_length = out_length_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("list length above depth");

    a_count_only_on_apply : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_APPLY |=> $stable(count_reg))
        else $error("list length changed outside apply step");

    a_result_from_done : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result item raised outside done step");

    a_busy_while_scanning : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |=> !out_valid_reg || !$rose(out_valid_reg))
        else $error("result item raised during scan");

endmodule

@@ hdl/sle_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: holds an entry, shifts with its neighbors and passes
// the lookup probe one slot further each cycle.
// ----------------------------------------------------------------------------
module sle_cell
    import sle_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 8
) (
    input  logic                    clk,
    input  ctrl_t                   ctrl,
    input  logic [CNT_W-1:0]        count,
    input  logic signed [VAL_W-1:0] left_value,
    input  logic signed [VAL_W-1:0] right_value,
    input  probe_t                  probe_in,
    output logic signed [VAL_W-1:0] value,
    output probe_t                  probe_out
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    probe_t                  probe_reg;
    probe_t                  probe_next;
    logic [CMP_W-1:0]        idx;
    logic [CMP_W-1:0]        pos_x;
    logic                    live;
    logic                    at_pos;
    logic                    past_pos;
    logic                    match;

    assign idx      = CMP_W'(INDEX);
    assign pos_x    = CMP_W'(ctrl.position);
    assign live     = idx < CMP_W'(count);
    assign at_pos   = idx == pos_x;
    assign past_pos = idx > pos_x;
    assign match    = live && ((ctrl.op == OP_SEARCH) ? (value_reg == ctrl.item_value)
                                                      : at_pos);

    always_comb
    begin
        if (probe_in.hit)
        begin
            probe_next = probe_in;
        end
        else
        begin
            probe_next.hit   = match;
            probe_next.value = value_reg;
            probe_next.index = FOUND_W'(INDEX);
        end
    end

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.apply)
        begin
            unique case (ctrl.op)
                OP_INSERT:
                begin
                    if (past_pos)
                        value_next = left_value;
                    else if (at_pos)
                        value_next = ctrl.item_value;
                end
                OP_DELETE:
                begin
                    if (past_pos || at_pos)
                        value_next = right_value;
                end
                OP_OVERWRITE:
                begin
                    if (at_pos)
                        value_next = ctrl.item_value;
                end
                default:
                begin
                    value_next = value_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        probe_reg <= probe_next;
    end

    assign value     = value_reg;
    assign probe_out = probe_reg;

endmodule
